>>> src/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// Types, character constants and class helpers shared by the tokenizer.
// ----------------------------------------------------------------------------
package pct_pkg;

    // Scan modes: what the held character is waiting on.
    typedef enum logic [4:0] {
        M_IDLE   = 5'b00001,
        M_SIGN   = 5'b00010,
        M_LT     = 5'b00100,
        M_IDENT  = 5'b01000,
        M_NUMBER = 5'b10000
    } t_mode;

    typedef enum logic [1:0] {
        CLS_NUMBER = 2'd0,
        CLS_OP     = 2'd1,
        CLS_IDENT  = 2'd2,
        CLS_UNK    = 2'd3
    } t_class;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // One result beat.
    typedef struct packed {
        logic [7:0] lex_char;
        t_class     token_class;
        logic       token_end;
        logic       last;
    } t_result;

    // Results produced by one input beat, handed to the result queue.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {CH_SPACE, [CH_TAB:CH_CR]});
    endfunction

    function automatic logic is_single_op(input logic [7:0] c);
        return (c inside {CH_STAR, CH_SLASH, CH_EQ, CH_GT, CH_AMP, CH_BAR});
    endfunction

endpackage

>>> src/pct_in_if.sv
// ----------------------------------------------------------------------------
// pct_in_if
// Input byte channel: valid/ready with one text byte and end-of-text flag.
// ----------------------------------------------------------------------------
interface pct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

>>> src/pct_out_if.sv
// ----------------------------------------------------------------------------
// pct_out_if
// Result channel: valid/ready with one tagged token character.
// ----------------------------------------------------------------------------
interface pct_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] lex_char;
    logic [1:0] token_class;
    logic       token_end;
    logic       last;

    modport source (output valid, output lex_char, output token_class,
                    output token_end, output last, input ready);
    modport sink   (input valid, input lex_char, input token_class,
                    input token_end, input last, output ready);
endinterface

>>> src/priority_char_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// priority_char_tokenizer_unit
// Streaming maximal-munch tokenizer with one byte of lookahead.
// ----------------------------------------------------------------------------
// Feed the text one byte per input beat and flag the final byte with
// end_of_text. Each byte yields zero, one or two result beats, each a lexeme
// character with its class (number, operator, identifier, unknown), an
// end-of-token mark and a last mark on the final result of that byte.
// Whitespace yields nothing. Bytes that may continue a token (signs, '<',
// letters, digits) are held one beat, so their results come out with the
// next byte or at end of text. A new byte is taken every cycle while the
// four-entry result queue has two free slots; the first result is in the
// queue the cycle after the byte is taken. The output port drains one result
// a cycle while ready, so two-result bytes slow the input to the output rate.
// ----------------------------------------------------------------------------
module priority_char_tokenizer_unit
    import pct_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    pct_in_if.sink         i_in,
    pct_out_if.source      o_out
);

    t_step   step;
    t_result head;
    logic    room;
    logic    fire;

    // take a byte only when the queue can absorb its worst case of two results
    assign i_in.ready = room;
    assign fire       = i_in.valid && room;

    // scan state and lookahead decision
    pct_lex u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_ch    (i_in.ch),
        .i_eot   (i_in.end_of_text),
        .o_step  (step)
    );

    // hold results until the sink takes each beat
    pct_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_push  (fire),
        .o_room  (room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (head)
    );

    assign o_out.lex_char    = head.lex_char;
    assign o_out.token_class = head.token_class;
    assign o_out.token_end   = head.token_end;
    assign o_out.last        = head.last;

endmodule

>>> src/pct_lex.sv
// ----------------------------------------------------------------------------
// pct_lex
// Scan state (mode and held byte) and the one-byte lookahead decision.
// ----------------------------------------------------------------------------
module pct_lex
    import pct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_ch,
    input  logic       i_eot,
    output t_step      o_step
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_held, n_held;

    t_result    res [2];
    logic [1:0] cnt;
    logic       take_bt;

    always_comb begin
        res[0]  = '0;
        res[1]  = '0;
        cnt     = 2'd0;
        take_bt = 1'b0;
        n_mode  = r_mode;
        n_held  = r_held;

        case (r_mode)
            M_SIGN: begin
                if (is_digit(i_ch)) begin
                    res[cnt[0]] = '{r_held, CLS_NUMBER, 1'b0, 1'b0};
                    cnt = cnt + 2'd1;
                    n_mode = M_NUMBER;
                    n_held = i_ch;
                end else begin
                    res[cnt[0]] = '{r_held, CLS_OP, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                    take_bt = 1'b1;
                end
            end
            M_LT: begin
                if (i_ch == CH_EQ || i_ch == CH_LT) begin
                    res[0] = '{r_held, CLS_OP, 1'b0, 1'b0};
                    res[1] = '{i_ch, CLS_OP, 1'b1, 1'b0};
                    cnt = 2'd2;
                    n_mode = M_IDLE;
                end else begin
                    res[cnt[0]] = '{r_held, CLS_OP, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                    take_bt = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_letter(i_ch) || is_digit(i_ch)) begin
                    res[cnt[0]] = '{r_held, CLS_IDENT, 1'b0, 1'b0};
                    cnt = cnt + 2'd1;
                    n_held = i_ch;
                end else begin
                    res[cnt[0]] = '{r_held, CLS_IDENT, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                    take_bt = 1'b1;
                end
            end
            M_NUMBER: begin
                if (is_digit(i_ch)) begin
                    res[cnt[0]] = '{r_held, CLS_NUMBER, 1'b0, 1'b0};
                    cnt = cnt + 2'd1;
                    n_held = i_ch;
                end else begin
                    res[cnt[0]] = '{r_held, CLS_NUMBER, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                    take_bt = 1'b1;
                end
            end
            default: begin
                take_bt = 1'b1;
            end
        endcase

        // start a new token with the incoming byte
        if (take_bt) begin
            n_mode = M_IDLE;
            if (is_space(i_ch)) begin
                n_mode = M_IDLE;
            end else if (i_ch == CH_PLUS || i_ch == CH_MINUS) begin
                n_mode = M_SIGN;
                n_held = i_ch;
            end else if (i_ch == CH_LT) begin
                n_mode = M_LT;
                n_held = i_ch;
            end else if (is_letter(i_ch)) begin
                n_mode = M_IDENT;
                n_held = i_ch;
            end else if (is_digit(i_ch)) begin
                n_mode = M_NUMBER;
                n_held = i_ch;
            end else if (is_single_op(i_ch)) begin
                res[cnt[0]] = '{i_ch, CLS_OP, 1'b1, 1'b0};
                cnt = cnt + 2'd1;
            end else begin
                res[cnt[0]] = '{i_ch, CLS_UNK, 1'b1, 1'b0};
                cnt = cnt + 2'd1;
            end
        end

        // flush whatever is held at end of text
        if (i_eot) begin
            case (n_mode)
                M_SIGN, M_LT: begin
                    res[cnt[0]] = '{n_held, CLS_OP, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                end
                M_IDENT: begin
                    res[cnt[0]] = '{n_held, CLS_IDENT, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                end
                M_NUMBER: begin
                    res[cnt[0]] = '{n_held, CLS_NUMBER, 1'b1, 1'b0};
                    cnt = cnt + 2'd1;
                end
                default: begin
                end
            endcase
            n_mode = M_IDLE;
        end

        case (cnt)
            2'd1:    res[0].last = 1'b1;
            2'd2:    res[1].last = 1'b1;
            default: begin
            end
        endcase
    end

    assign o_step.count = cnt;
    assign o_step.res0  = res[0];
    assign o_step.res1  = res[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_held <= 8'h00;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_held <= n_held;
        end
    end

endmodule

>>> src/pct_fifo.sv
// ----------------------------------------------------------------------------
// pct_fifo
// Four-entry result queue: up to two results in a cycle, one out on ready.
// ----------------------------------------------------------------------------
module pct_fifo
    import pct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_step   i_step,
    input  logic    i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    localparam int Depth = 4;
    localparam int AW    = $clog2(Depth);
    localparam int CW    = AW + 1;

    t_result         r_mem [Depth];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   push_n;
    logic            pop;

    assign o_room  = (r_count <= CW'(Depth - 2));
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rptr];
    assign pop     = o_valid && i_ready;
    assign push_n  = i_push ? CW'(i_step.count) : '0;

    always_comb begin
        n_wptr  = r_wptr + AW'(push_n);
        n_rptr  = r_rptr + AW'(pop);
        n_count = r_count + push_n - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_n != '0) begin
            r_mem[r_wptr] <= i_step.res0;
        end
        if (push_n == CW'(2)) begin
            r_mem[r_wptr + AW'(1)] <= i_step.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

>>> sim/tb_priority_char_tokenizer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_char_tokenizer_unit
// Self-checking bench for the streaming tokenizer: drives texts byte by byte,
// predicts the tagged lexeme characters and checks every result beat in order.
// ----------------------------------------------------------------------------
// A short directed run hits the operator pairs, signs, whitespace, zero and
// top byte values and each kind of token left open at end of text. Random
// texts follow: mostly well-formed token streams with random content, plus
// noise bytes. Both sides stall at random in two of three pressure phases.
// ----------------------------------------------------------------------------
module tb_priority_char_tokenizer_unit;
    import pct_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 430;

    // Byte categories as the predictor sees them.
    typedef enum logic [2:0] {
        K_BLANK, K_SIGN, K_LESS, K_LETTER, K_DIGIT, K_SINGLE, K_OTHER
    } t_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pct_in_if  in_if ();
    pct_out_if out_if ();

    priority_char_tokenizer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state: what the held byte waits on, and the byte itself.
    t_mode      lex_state = M_IDLE;
    logic [7:0] lex_held  = 8'h00;

    t_result    pending_lexemes[$];
    logic [7:0] text_buf[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;
    int texts_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int stall_cycles  = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic t_kind kind_of(input logic [7:0] c);
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            return K_BLANK;
        if (c == CH_PLUS || c == CH_MINUS)
            return K_SIGN;
        if (c == CH_LT)
            return K_LESS;
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
            return K_LETTER;
        if (c >= "0" && c <= "9")
            return K_DIGIT;
        if (c == CH_STAR || c == CH_SLASH || c == CH_EQ || c == CH_GT ||
            c == CH_AMP || c == CH_BAR)
            return K_SINGLE;
        return K_OTHER;
    endfunction

    function automatic void add_lexeme(input logic [7:0] c, input t_class cls,
                                       input logic fin);
        t_result r;
        r.lex_char    = c;
        r.token_class = cls;
        r.token_end   = fin;
        r.last        = 1'b0;
        pending_lexemes.insert(pending_lexemes.size(), r);
    endfunction

    // Start a token from idle: hold bytes that may go on, drop blanks, give out the rest.
    function automatic void open_token(input logic [7:0] c);
        lex_state = M_IDLE;
        case (kind_of(c))
            K_BLANK:  ;
            K_SIGN: begin
                lex_state = M_SIGN;
                lex_held  = c;
            end
            K_LESS: begin
                lex_state = M_LT;
                lex_held  = c;
            end
            K_LETTER: begin
                lex_state = M_IDENT;
                lex_held  = c;
            end
            K_DIGIT: begin
                lex_state = M_NUMBER;
                lex_held  = c;
            end
            K_SINGLE: add_lexeme(c, CLS_OP, 1'b1);
            default:  add_lexeme(c, CLS_UNK, 1'b1);
        endcase
    endfunction

    function automatic void tokenize_byte(input logic [7:0] c, input logic eot);
        t_kind   k;
        int      base;
        k    = kind_of(c);
        base = pending_lexemes.size();
        case (lex_state)
            M_SIGN: begin
                if (k == K_DIGIT) begin
                    add_lexeme(lex_held, CLS_NUMBER, 1'b0);
                    lex_state = M_NUMBER;
                    lex_held  = c;
                end else begin
                    add_lexeme(lex_held, CLS_OP, 1'b1);
                    open_token(c);
                end
            end
            M_LT: begin
                if (c == CH_EQ || c == CH_LT) begin
                    add_lexeme(lex_held, CLS_OP, 1'b0);
                    add_lexeme(c, CLS_OP, 1'b1);
                    lex_state = M_IDLE;
                end else begin
                    add_lexeme(lex_held, CLS_OP, 1'b1);
                    open_token(c);
                end
            end
            M_IDENT: begin
                if (k == K_LETTER || k == K_DIGIT) begin
                    add_lexeme(lex_held, CLS_IDENT, 1'b0);
                    lex_held = c;
                end else begin
                    add_lexeme(lex_held, CLS_IDENT, 1'b1);
                    open_token(c);
                end
            end
            M_NUMBER: begin
                if (k == K_DIGIT) begin
                    add_lexeme(lex_held, CLS_NUMBER, 1'b0);
                    lex_held = c;
                end else begin
                    add_lexeme(lex_held, CLS_NUMBER, 1'b1);
                    open_token(c);
                end
            end
            default: open_token(c);
        endcase

        // End of text: flush whatever is still held and go idle.
        if (eot) begin
            case (lex_state)
                M_SIGN, M_LT: add_lexeme(lex_held, CLS_OP, 1'b1);
                M_IDENT:      add_lexeme(lex_held, CLS_IDENT, 1'b1);
                M_NUMBER:     add_lexeme(lex_held, CLS_NUMBER, 1'b1);
                default:      ;
            endcase
            lex_state = M_IDLE;
        end

        if (pending_lexemes.size() > base)
            pending_lexemes[pending_lexemes.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: entered and left just after a falling edge
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic eot);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.ch          <= c;
        in_if.end_of_text <= eot;
        do @(posedge i_clk); while (!in_if.ready);
        tokenize_byte(c, eot);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
        texts_sent++;
    endtask

    task automatic send_buffer();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        texts_sent++;
        text_buf.delete();
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls and in-order checking
    // ------------------------------------------------------------------------
    always @(negedge i_clk)
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge i_clk) begin : check_result
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (pending_lexemes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result char %02h class %0d end %b last %b",
                             out_if.lex_char, out_if.token_class, out_if.token_end,
                             out_if.last);
            end else begin
                want = pending_lexemes.pop_front();
                if (out_if.lex_char !== want.lex_char ||
                    out_if.token_class !== want.token_class ||
                    out_if.token_end !== want.token_end ||
                    out_if.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: result %0d expected char %02h class %0d end %b last %b",
                                 results_seen, want.lex_char, want.token_class,
                                 want.token_end, want.last);
                        $display("       got char %02h class %0d end %b last %b",
                                 out_if.lex_char, out_if.token_class, out_if.token_end,
                                 out_if.last);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("ERROR: no beat for %0d cycles, %0d results outstanding",
                     stall_cycles, pending_lexemes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Sign before a sign, signed number, '<' '=' pair, identifier open at end.
    // Then '<' '<' pair, single operators and a lone sign at end of text.
    task automatic test_operators_and_signs();
        send_text("+-5<=a1");
        send_text("<<x*/>&|-");
    endtask

    // Every whitespace byte, then '=' and a lone '<' at end of text.
    task automatic test_whitespace_and_open_lt();
        for (int c = int'(CH_TAB); c <= int'(CH_CR); c++)
            send_byte(c[7:0], 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_EQ, 1'b0);
        send_byte(CH_LT, 1'b1);
        texts_sent++;
    endtask

    // Zero and top byte are unknown tokens; a number left open at end.
    task automatic test_unusual_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("9", 1'b1);
        texts_sent++;
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0)
            return 8'(8'h61 + $urandom_range(0, 25));
        return 8'(8'h41 + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_blank();
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? CH_SPACE : 8'(int'(CH_TAB) + pick);
    endfunction

    // Append one byte to the text under construction.
    function automatic void queue_byte(input logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    // Append one random token, sometimes followed by whitespace.
    function automatic void add_random_token();
        int n;
        case ($urandom_range(0, 10))
            0, 1, 2: begin
                queue_byte(rand_letter());
                n = $urandom_range(0, 5);
                repeat (n)
                    queue_byte($urandom_range(0, 1) ? rand_letter() : rand_digit());
            end
            3, 4: begin
                if ($urandom_range(0, 2) == 0)
                    queue_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                n = $urandom_range(1, 5);
                repeat (n)
                    queue_byte(rand_digit());
            end
            5: begin
                queue_byte(CH_LT);
                case ($urandom_range(0, 2))
                    0: queue_byte(CH_EQ);
                    1: queue_byte(CH_LT);
                    default: ;
                endcase
            end
            6: begin
                case ($urandom_range(0, 5))
                    0: queue_byte(CH_STAR);
                    1: queue_byte(CH_SLASH);
                    2: queue_byte(CH_EQ);
                    3: queue_byte(CH_GT);
                    4: queue_byte(CH_AMP);
                    default: queue_byte(CH_BAR);
                endcase
            end
            7: queue_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            8: begin
                n = $urandom_range(1, 3);
                repeat (n)
                    queue_byte(rand_blank());
            end
            default: queue_byte(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 1) == 0)
            queue_byte(rand_blank());
    endfunction

    // Random texts until enough bytes have gone in.
    task automatic test_random_texts(input int n_items);
        int goal;
        int n;
        goal = bytes_sent + n_items;
        while (bytes_sent < goal) begin
            n = $urandom_range(1, 10);
            if ($urandom_range(0, 19) == 0) begin
                // broken text: raw noise over the whole byte range
                repeat (n)
                    queue_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat (n)
                    add_random_token();
            end
            send_buffer();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.ch          = 8'h00;
        in_if.end_of_text = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 21;
        recv_idle_pct = 54;
        test_operators_and_signs();
        test_whitespace_and_open_lt();
        test_unusual_bytes();
        test_random_texts(PHASE_ITEMS);

        send_idle_pct = 54;
        recv_idle_pct = 21;
        test_random_texts(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_texts(PHASE_ITEMS);

        in_if.valid <= 1'b0;
        while (pending_lexemes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d texts, %0d bytes in, checked %0d result beats",
                 texts_sent, bytes_sent, results_seen);
        $display("Mismatches: %0d, results still outstanding: %0d",
                 mismatches, pending_lexemes.size());
        if (mismatches == 0 && pending_lexemes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
